[hdl/dpr_pkg.sv]
// Package: shared constants, types and register codes of the delta pair prefetcher.
`timescale 1ns / 1ps
package dpr_pkg;

    localparam int ADDR_WIDTH    = 32;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int SCORE_W       = 32;
    localparam int CFG_W         = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SCORE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_BOOST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_MARGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PHYS_ADDR = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0]      base_score;
        logic [CFG_W-1:0]      hit_boost;
        logic [CFG_W-1:0]      miss_penalty;
        logic [CFG_W-1:0]      kick_margin;
        logic [ADDR_WIDTH-1:0] max_phys_addr;
    } cfg_t;

    // One classified access as handed from front to back.
    typedef struct packed {
        logic [ADDR_WIDTH-1:0] addr;
        logic [ADDR_WIDTH-1:0] delta;
        logic [ADDR_WIDTH-1:0] prev_delta;
        logic                  train;
    } item_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] older;
        logic [ADDR_WIDTH-1:0] newer;
        logic [ADDR_WIDTH-1:0] cand;
        logic [SCORE_W-1:0]    score;
    } entry_t;

    localparam int ITEM_W  = $bits(item_t);
    localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/dpr_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module dpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/dpr_front.sv]
// Front end: accept accesses, form the delta and classify them for training.
`timescale 1ns / 1ps
module dpr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dpr_pkg::ADDR_WIDTH-1:0] access_addr,
    output logic                           push,
    output dpr_pkg::item_t                 push_item,
    input  logic                           q_full
);
    import dpr_pkg::*;

    logic [ADDR_WIDTH-1:0] last_addr_reg, last_addr_next;
    logic [ADDR_WIDTH-1:0] last_delta_reg, last_delta_next;
    logic [ADDR_WIDTH-1:0] delta;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign delta    = access_addr - last_addr_reg;

    always_comb
    begin
        push_item.addr       = access_addr;
        push_item.delta      = delta;
        push_item.prev_delta = last_delta_reg;
        push_item.train      = (last_addr_reg != '0);
        last_addr_next       = push ? access_addr : last_addr_reg;
        last_delta_next      = push ? delta : last_delta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_addr_reg  <= '0;
            last_delta_reg <= '0;
        end
        else
        begin
            last_addr_reg  <= last_addr_next;
            last_delta_reg <= last_delta_next;
        end
    end
endmodule

[hdl/dpr_queue.sv]
// Short queue between front and back.
`timescale 1ns / 1ps
module dpr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dpr_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output dpr_pkg::item_t q_item
);
    import dpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t                store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       fill_reg, fill_next;

    assign full    = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = store_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end
endmodule

[hdl/dpr_back.sv]
// Back end: scan the correlation table, train it, allocate or evict, and predict.
`timescale 1ns / 1ps
module dpr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dpr_pkg::cfg_t                  cfg,
    input  logic                           q_valid,
    input  dpr_pkg::item_t                 q_item,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           prefetch_valid,
    output logic [dpr_pkg::ADDR_WIDTH-1:0] prefetch_addr
);
    import dpr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]               state_reg, state_next;
    item_t                    item_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [SCORE_W-1:0]       train_count_reg;
    logic [ADDR_WIDTH-1:0]    hist_older_reg, hist_newer_reg;

    logic [CNT_W-1:0]         rd_cnt_reg;
    logic                     ev_vld_reg;
    logic [IDX_W-1:0]         ev_idx_reg;

    logic                     t_hit_reg, p_hit_reg, inv_found_reg, best_vld_reg;
    logic [IDX_W-1:0]         t_idx_reg, p_idx_reg, inv_idx_reg, best_idx_reg;
    entry_t                   t_entry_reg, best_entry_reg;
    logic [ADDR_WIDTH-1:0]    p_cand_reg;

    logic                     res_pv_reg;
    logic [ADDR_WIDTH-1:0]    res_pa_reg;
    logic                     out_vld_reg, out_pv_reg;
    logic [ADDR_WIDTH-1:0]    out_pa_reg;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    entry_t                   ram_wdata, rd_entry;
    logic [ENTRY_W-1:0]       ram_rdata;

    logic                     ev_valid, ev_better, ev_greater;
    logic [SCORE_W:0]         fresh_sum, boost_sum, kick_lim;
    logic [SCORE_W-1:0]       fresh;
    entry_t                   upd;
    logic                     full, do_alloc, do_update, evict_p, new_is_pkey;
    logic [IDX_W-1:0]         alloc_idx;
    logic [ADDR_WIDTH-1:0]    pred, pa;
    logic                     load_out;

    dpr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign load_out = (state_reg == S_RESULT) && (!out_vld_reg || out_ready);

    assign out_valid      = out_vld_reg;
    assign prefetch_valid = out_pv_reg;
    assign prefetch_addr  = out_pa_reg;

    // Scan compare: valid bit of the entry in flight and eviction ordering.
    always_comb
    begin
        ev_valid   = valid_reg[ev_idx_reg];
        if (rd_entry.older != best_entry_reg.older)
        begin
            ev_greater = $signed(rd_entry.older) > $signed(best_entry_reg.older);
        end
        else
        begin
            ev_greater = $signed(rd_entry.newer) > $signed(best_entry_reg.newer);
        end
        ev_better = !best_vld_reg || (rd_entry.score < best_entry_reg.score) ||
                    ((rd_entry.score == best_entry_reg.score) && ev_greater);
    end

    // Training update of the matched entry and allocation choice.
    always_comb
    begin
        fresh_sum = {1'b0, train_count_reg} + {{(SCORE_W-CFG_W+1){1'b0}}, cfg.base_score};
        fresh     = fresh_sum[SCORE_W] ? '1 : fresh_sum[SCORE_W-1:0];
        boost_sum = {1'b0, t_entry_reg.score} + {{(SCORE_W-CFG_W+1){1'b0}}, cfg.hit_boost};
        kick_lim  = {1'b0, train_count_reg} + {{(SCORE_W-CFG_W+1){1'b0}}, cfg.kick_margin};
        upd       = t_entry_reg;
        if (t_entry_reg.cand == item_reg.delta)
        begin
            if (t_entry_reg.score < fresh)
            begin
                upd.score = fresh;
            end
            else
            begin
                upd.score = boost_sum[SCORE_W] ? '1 : boost_sum[SCORE_W-1:0];
            end
        end
        else if ({1'b0, t_entry_reg.score} <= kick_lim)
        begin
            upd.cand  = item_reg.delta;
            upd.score = fresh;
        end
        else if (t_entry_reg.score > {{(SCORE_W-CFG_W){1'b0}}, cfg.miss_penalty})
        begin
            upd.score = t_entry_reg.score - {{(SCORE_W-CFG_W){1'b0}}, cfg.miss_penalty};
        end
        else
        begin
            upd.score = '0;
        end

        full        = (count_reg == CNT_W'(TABLE_ENTRIES));
        do_update   = t_hit_reg && (item_reg.delta != '0);
        do_alloc    = !t_hit_reg && (hist_older_reg != '0) && (hist_newer_reg != '0);
        alloc_idx   = full ? best_idx_reg : inv_idx_reg;
        evict_p     = do_alloc && full && (p_idx_reg == best_idx_reg);
        new_is_pkey = do_alloc && (hist_older_reg == item_reg.prev_delta) &&
                      (hist_newer_reg == item_reg.delta);

        ram_we          = (state_reg == S_APPLY) && (do_update || do_alloc);
        ram_waddr       = t_hit_reg ? t_idx_reg : alloc_idx;
        ram_wdata       = upd;
        if (!t_hit_reg)
        begin
            ram_wdata.older = hist_older_reg;
            ram_wdata.newer = hist_newer_reg;
            ram_wdata.cand  = '0;
            ram_wdata.score = fresh;
        end

        // Prediction sees the table as it stands after training.
        if (new_is_pkey || !p_hit_reg || evict_p)
        begin
            pred = '0;
        end
        else if (do_update && (p_idx_reg == t_idx_reg))
        begin
            pred = upd.cand;
        end
        else
        begin
            pred = p_cand_reg;
        end
        pa = item_reg.addr + pred;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.train ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN:
            begin
                if ((rd_cnt_reg == CNT_W'(TABLE_ENTRIES)) && !ev_vld_reg)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Payload and scan trackers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg   <= q_item;
            res_pv_reg <= 1'b0;
            res_pa_reg <= q_item.addr;
        end
        if (state_reg == S_SCAN && ev_vld_reg && ev_valid)
        begin
            if (rd_entry.older == hist_older_reg && rd_entry.newer == hist_newer_reg)
            begin
                t_idx_reg   <= ev_idx_reg;
                t_entry_reg <= rd_entry;
            end
            if (rd_entry.older == item_reg.prev_delta && rd_entry.newer == item_reg.delta)
            begin
                p_idx_reg  <= ev_idx_reg;
                p_cand_reg <= rd_entry.cand;
            end
            if (ev_better)
            begin
                best_idx_reg   <= ev_idx_reg;
                best_entry_reg <= rd_entry;
            end
        end
        if (state_reg == S_SCAN && ev_vld_reg && !ev_valid && !inv_found_reg)
        begin
            inv_idx_reg <= ev_idx_reg;
        end
        if (state_reg == S_APPLY)
        begin
            res_pa_reg <= pa;
            res_pv_reg <= (pa < cfg.max_phys_addr) && (pa != item_reg.addr);
        end
        if (load_out)
        begin
            out_pv_reg <= res_pv_reg;
            out_pa_reg <= res_pa_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            count_reg       <= '0;
            train_count_reg <= '0;
            hist_older_reg  <= '0;
            hist_newer_reg  <= '0;
            rd_cnt_reg      <= '0;
            ev_vld_reg      <= 1'b0;
            ev_idx_reg      <= '0;
            t_hit_reg       <= 1'b0;
            p_hit_reg       <= 1'b0;
            inv_found_reg   <= 1'b0;
            best_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                rd_cnt_reg    <= '0;
                ev_vld_reg    <= 1'b0;
                t_hit_reg     <= 1'b0;
                p_hit_reg     <= 1'b0;
                inv_found_reg <= 1'b0;
                best_vld_reg  <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                ev_vld_reg <= (rd_cnt_reg != CNT_W'(TABLE_ENTRIES));
                ev_idx_reg <= rd_cnt_reg[IDX_W-1:0];
                if (rd_cnt_reg != CNT_W'(TABLE_ENTRIES))
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (ev_vld_reg && ev_valid)
                begin
                    if (rd_entry.older == hist_older_reg && rd_entry.newer == hist_newer_reg)
                    begin
                        t_hit_reg <= 1'b1;
                    end
                    if (rd_entry.older == item_reg.prev_delta &&
                        rd_entry.newer == item_reg.delta)
                    begin
                        p_hit_reg <= 1'b1;
                    end
                    if (ev_better)
                    begin
                        best_vld_reg <= 1'b1;
                    end
                end
                if (ev_vld_reg && !ev_valid)
                begin
                    inv_found_reg <= 1'b1;
                end
            end
            if (state_reg == S_APPLY)
            begin
                if (do_alloc && !full)
                begin
                    valid_reg[alloc_idx] <= 1'b1;
                    count_reg            <= count_reg + 1'b1;
                end
                hist_older_reg  <= hist_newer_reg;
                hist_newer_reg  <= item_reg.delta;
                train_count_reg <= train_count_reg + 1'b1;
            end
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end
endmodule

[hdl/delta_pair_correlation_prefetcher_core.sv]
// Top level of the delta pair correlation prefetcher.
`timescale 1ns / 1ps
// A training access is popped from the queue, scanned over the whole table through the single
// read port of the table RAM, one entry a cycle, applied, and then loaded into the output
// register; one that does not train goes straight from the queue to the result. The back end
// pops no new access until the current result has been loaded into the output register.
// Reset: asynchronous, active low; clears history, counts, valid bits and loads register
// defaults. Table contents are left as they are and are masked by the valid bits.
module delta_pair_correlation_prefetcher_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dpr_pkg::ADDR_WIDTH-1:0]  access_addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            prefetch_valid,
    output logic [dpr_pkg::ADDR_WIDTH-1:0]  prefetch_addr,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dpr_pkg::DATA_W-1:0]      cfg_data
);
    import dpr_pkg::*;

    cfg_t  cfg_reg;
    logic  push, q_full, q_valid, pop;
    item_t push_item, q_item;

    // Take register writes in any cycle; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_score    <= CFG_W'(10000);
            cfg_reg.hit_boost     <= CFG_W'(500);
            cfg_reg.miss_penalty  <= CFG_W'(2000);
            cfg_reg.kick_margin   <= '0;
            cfg_reg.max_phys_addr <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_SCORE:    cfg_reg.base_score    <= cfg_data[CFG_W-1:0];
                REG_HIT_BOOST:     cfg_reg.hit_boost     <= cfg_data[CFG_W-1:0];
                REG_MISS_PENALTY:  cfg_reg.miss_penalty  <= cfg_data[CFG_W-1:0];
                REG_KICK_MARGIN:   cfg_reg.kick_margin   <= cfg_data[CFG_W-1:0];
                REG_MAX_PHYS_ADDR: cfg_reg.max_phys_addr <= cfg_data[ADDR_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    // Front: form the delta and classify each transaction.
    dpr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .access_addr (access_addr),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    // Decouple front and back so each can stall on its own.
    dpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back: scan, train, allocate and predict; result held in an output register.
    dpr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prefetch_valid (prefetch_valid),
        .prefetch_addr  (prefetch_addr)
    );
endmodule

[hdl/dpr_checker.sv]
// Port level checker for the prefetcher core, bound to the top level.
`timescale 1ns / 1ps
module dpr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           prefetch_valid,
    input logic [dpr_pkg::ADDR_WIDTH-1:0] prefetch_addr,
    input logic                           cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prefetch_addr) &&
        $stable(prefetch_valid))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result shown right after reset");

    a_ready_after_reset: assert property (@(posedge clk) $past(!rst_n) && rst_n |-> in_ready)
        else $error("input not ready after reset");

    a_cfg_ready: assert property (@(posedge clk) rst_n |-> cfg_ready)
        else $error("register write port stalled");
endmodule

bind delta_pair_correlation_prefetcher_core dpr_checker u_dpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prefetch_valid (prefetch_valid),
    .prefetch_addr  (prefetch_addr),
    .cfg_ready      (cfg_ready)
);

[tb/sv/dpr_checker.sv]
// Checker: watches the channels, predicts every prefetch result and compares.
`timescale 1ns / 1ps
module tb_checker
    import dpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [ADDR_WIDTH-1:0] access_addr,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  prefetch_valid,
    input  logic [ADDR_WIDTH-1:0] prefetch_addr,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,
    output int unsigned           errors,
    output int unsigned           pending
);

    localparam logic [63:0] SCORE_SAT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic                  issue;
        logic [ADDR_WIDTH-1:0] addr;
    } prefetch_t;

    prefetch_t             prefetch_q[$];
    cfg_t                  regs;
    bit                    ent_vld[TABLE_ENTRIES];
    logic [ADDR_WIDTH-1:0] ent_older[TABLE_ENTRIES];
    logic [ADDR_WIDTH-1:0] ent_newer[TABLE_ENTRIES];
    logic [ADDR_WIDTH-1:0] ent_cand[TABLE_ENTRIES];
    logic [63:0]           ent_score[TABLE_ENTRIES];
    int unsigned           n_used;
    logic [31:0]           n_trained;
    logic [ADDR_WIDTH-1:0] prev_addr, prev_delta, h_older, h_newer;

    assign pending = prefetch_q.size();

    function automatic logic [63:0] sat(input logic [63:0] v);
        return (v > SCORE_SAT) ? SCORE_SAT : v;
    endfunction

    function automatic int find_key(input logic [ADDR_WIDTH-1:0] older, newer);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (ent_vld[i] && ent_older[i] == older && ent_newer[i] == newer)
                return i;
        return -1;
    endfunction

    // signed key order: older delta first, newer delta breaks the tie
    function automatic bit key_above(input int a, input int b);
        if (ent_older[a] != ent_older[b])
            return $signed(ent_older[a]) > $signed(ent_older[b]);
        return $signed(ent_newer[a]) > $signed(ent_newer[b]);
    endfunction

    function automatic void insert_key(input logic [ADDR_WIDTH-1:0] older, newer);
        int victim;
        logic [63:0] fresh;
        fresh  = sat(64'(n_trained) + 64'(regs.base_score));
        victim = -1;
        if (n_used >= TABLE_ENTRIES)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (!ent_vld[i])
                    continue;
                if (victim < 0 || ent_score[i] < ent_score[victim] ||
                    (ent_score[i] == ent_score[victim] && key_above(i, victim)))
                    victim = i;
            end
            ent_vld[victim] = 1'b0;
            n_used--;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!ent_vld[i])
            begin
                ent_vld[i]   = 1'b1;
                ent_older[i] = older;
                ent_newer[i] = newer;
                ent_cand[i]  = '0;
                ent_score[i] = fresh;
                n_used++;
                return;
            end
        end
    endfunction

    function automatic void learn_delta(input logic [ADDR_WIDTH-1:0] d);
        int k;
        logic [63:0] fresh;
        fresh = sat(64'(n_trained) + 64'(regs.base_score));
        k = find_key(h_older, h_newer);
        if (k >= 0)
        begin
            if (d != 0)
            begin
                if (ent_cand[k] == d)
                    ent_score[k] = (ent_score[k] < fresh) ? fresh
                                 : sat(ent_score[k] + 64'(regs.hit_boost));
                else if (ent_score[k] <= 64'(n_trained) + 64'(regs.kick_margin))
                begin
                    ent_cand[k]  = d;
                    ent_score[k] = fresh;
                end
                else
                    ent_score[k] = (ent_score[k] > 64'(regs.miss_penalty))
                                 ? ent_score[k] - 64'(regs.miss_penalty) : 64'd0;
            end
        end
        else if (h_older != 0 && h_newer != 0)
            insert_key(h_older, h_newer);
        h_older   = h_newer;
        h_newer   = d;
        n_trained = n_trained + 1;
    endfunction

    function automatic prefetch_t predict_prefetch(input logic [ADDR_WIDTH-1:0] a);
        logic [ADDR_WIDTH-1:0] d, guess;
        prefetch_t r;
        int k;
        guess = '0;
        d = a - prev_addr;
        if (prev_addr != 0)
        begin
            learn_delta(d);
            k = find_key(prev_delta, d);
            if (k >= 0)
                guess = ent_cand[k];
        end
        prev_delta = d;
        prev_addr  = a;
        r.addr  = a + guess;
        r.issue = (r.addr < regs.max_phys_addr) && (r.addr != a);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        prefetch_t want;
        if (!rst_n)
        begin
            regs       = '{base_score: 16'd10000, hit_boost: 16'd500, miss_penalty: 16'd2000,
                           kick_margin: 16'd0, max_phys_addr: '1};
            for (int i = 0; i < TABLE_ENTRIES; i++)
                ent_vld[i] = 1'b0;
            n_used     = 0;
            n_trained  = '0;
            prev_addr  = '0;
            prev_delta = '0;
            h_older    = '0;
            h_newer    = '0;
            errors     = 0;
            prefetch_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE_SCORE:    regs.base_score    = cfg_data[CFG_W-1:0];
                    REG_HIT_BOOST:     regs.hit_boost     = cfg_data[CFG_W-1:0];
                    REG_MISS_PENALTY:  regs.miss_penalty  = cfg_data[CFG_W-1:0];
                    REG_KICK_MARGIN:   regs.kick_margin   = cfg_data[CFG_W-1:0];
                    REG_MAX_PHYS_ADDR: regs.max_phys_addr = cfg_data[ADDR_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (prefetch_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("checker: unexpected result valid=%0b addr=%h",
                                 prefetch_valid, prefetch_addr);
                end
                else
                begin
                    want = prefetch_q.pop_front();
                    if (want.issue !== prefetch_valid || want.addr !== prefetch_addr)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("checker: mismatch exp valid=%0b addr=%h got valid=%0b addr=%h",
                                     want.issue, want.addr, prefetch_valid, prefetch_addr);
                    end
                end
            end
            if (in_valid && in_ready)
                prefetch_q.push_back(predict_prefetch(access_addr));
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top: clock, reset, stimulus and verdict for the delta pair prefetcher.
`timescale 1ns / 1ps
module tb_top;
    import dpr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = TABLE_ENTRIES + 16;   // a bit beyond the training latency
    localparam int LONG_HOLD   = 600;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ADDR_WIDTH-1:0] access_addr;
    logic                  out_valid;
    logic                  out_ready;
    logic                  prefetch_valid;
    logic [ADDR_WIDTH-1:0] prefetch_addr;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]     cfg_data;
    int unsigned           errors;
    int unsigned           pending;
    int unsigned           cycles;
    bit                    hold_req;
    logic [ADDR_WIDTH-1:0] walk_addr;

    delta_pair_correlation_prefetcher_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .access_addr   (access_addr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .prefetch_valid(prefetch_valid),
        .prefetch_addr (prefetch_addr),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tb_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Offer one access. All driving happens at the falling edge; acceptance is
    // seen at the rising edge. A zero gap keeps valid high into the next transaction.
    task automatic send_access(input logic [ADDR_WIDTH-1:0] a, input bit use_gap = 1);
        int gap;
        gap = use_gap ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;     // stretches of back-to-back traffic
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        access_addr = a;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold until every predicted result is back and the pipe has gone quiet.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic load_regs(input logic [15:0] start, boost, penalty, kick,
                             input logic [31:0] limit);
        drain();
        write_reg(REG_BASE_SCORE, 32'(start));
        write_reg(REG_HIT_BOOST, 32'(boost));
        write_reg(REG_MISS_PENALTY, 32'(penalty));
        write_reg(REG_KICK_MARGIN, 32'(kick));
        write_reg(REG_MAX_PHYS_ADDR, limit);
    endtask

    // Pick a delta: mostly small strides of either sign, sometimes anything.
    function automatic logic [ADDR_WIDTH-1:0] pick_delta();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return -($urandom_range(1, 256));
            default: return $urandom_range(1, 64) << $urandom_range(0, 6);
        endcase
    endfunction

    // Mostly repeating stride patterns with random content, so keys get hit,
    // refreshed and kicked; the rest is jumps, repeats and address zero.
    task automatic random_traffic(input int n_items);
        logic [ADDR_WIDTH-1:0] pat[4];
        int plen, reps, sent;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       walk_addr = '0;
                    1:       ;                      // same address again, zero delta
                    default: walk_addr = $urandom();
                endcase
                send_access(walk_addr);
                sent++;
            end
            else
            begin
                plen = $urandom_range(1, 4);
                for (int i = 0; i < plen; i++)
                    pat[i] = pick_delta();
                reps = $urandom_range(6, 30);
                for (int i = 0; i < reps && sent < n_items; i++)
                begin
                    // now and then break the pattern with a stray delta
                    walk_addr += ($urandom_range(0, 9) == 0) ? pick_delta() : pat[i % plen];
                    send_access(walk_addr);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stalls per result, and one long hold on request so the
    // block backs up and stalls its input.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        logic [ADDR_WIDTH-1:0] directed[$];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        access_addr = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_BASE_SCORE;
        cfg_data    = '0;
        hold_req    = 1'b0;
        walk_addr   = 32'h0001_0000;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: no previous address, steady stride (allocate, replace zero
        // candidate, then predict), zero delta, wraparound, address zero again.
        directed = '{32'h0, 32'h100, 32'h200, 32'h300, 32'h400, 32'h500, 32'h600,
                     32'h700, 32'h700, 32'h800, 32'h900, 32'hA00, 32'hFFFF_FFFF,
                     32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h5, 32'h15,
                     32'h25, 32'h35, 32'h45, 32'hFFFF_FFF0};
        foreach (directed[i])
            send_access(directed[i]);

        // Default registers, including the long receiver hold.
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_access(walk_addr + 32'(i) * 32'h40, 1'b0);
        random_traffic(260);

        // Zero scores and boost, maximum penalty and kick margin: ties on eviction.
        load_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
        random_traffic(230);

        // Score registers all at maximum and address limit zero: nothing may issue.
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);
        random_traffic(150);

        // Tight scores so candidates churn.
        load_regs(16'd5, 16'd1, 16'd1, 16'd3, 32'hFFFF_FFFF);
        random_traffic(250);

        load_regs(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  32'($urandom()));
        random_traffic(250);

        drain();
        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hdl/dpr_pkg.sv
hdl/dpr_ram.sv
hdl/dpr_front.sv
hdl/dpr_queue.sv
hdl/dpr_back.sv
hdl/delta_pair_correlation_prefetcher_core.sv
hdl/dpr_checker.sv
tb/sv/dpr_checker.sv
tb/sv/tb_top.sv
